/* hdl/gtpu_pkg.sv */
// shared types, codes and sizes of the gtp-u header parser
package gtpu_pkg;

    // width of the packet byte counter
    localparam int LENGTH_BITS = 16;
    // header offsets can run past the counter by one extension header
    localparam int HDR_W       = LENGTH_BITS + 1;
    // payload length difference, at least as wide as the reported field
    localparam int PLEN_W      = (HDR_W > 16) ? HDR_W : 16;

    typedef logic [LENGTH_BITS-1:0] t_count;
    typedef logic [HDR_W-1:0]       t_hdr;
    typedef logic [PLEN_W-1:0]      t_plen;

    // header constants
    localparam logic [7:0] VER_MASK     = 8'hE0;
    localparam logic [7:0] VER_ONE      = 8'h20;
    localparam logic [7:0] MSG_GPDU     = 8'hFF;
    localparam logic [7:0] EXT_NONE     = 8'h00;
    localparam logic [7:0] EXT_PDU_SESS = 8'h85;
    localparam logic [5:0] QFI_MASK     = 6'h3F;
    localparam int         FIXED_LEN    = 8;
    localparam int         OPT_END      = 12;
    localparam int         EXT_UNIT     = 4;

    // parse phase, one-hot
    typedef enum logic [5:0] {
        PH_FIXED    = 6'b000001,
        PH_OPT      = 6'b000010,
        PH_EXT_LEN  = 6'b000100,
        PH_EXT_BODY = 6'b001000,
        PH_PAYLOAD  = 6'b010000,
        PH_DROP     = 6'b100000
    } t_phase;

    // status reported on the final beat
    typedef enum logic [2:0] {
        ERR_OK        = 3'd0,
        ERR_SHORT     = 3'd1,
        ERR_VERSION   = 3'd2,
        ERR_NOT_GPDU  = 3'd3,
        ERR_SHORT_OPT = 3'd4,
        ERR_EXT_ZERO  = 3'd5,
        ERR_EXT_TRUNC = 3'd6,
        ERR_OVERFLOW  = 3'd7
    } t_err;

    // one result item
    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic        done_res;
        t_err        error_code;
        logic [31:0] tunnel_id;
        logic [5:0]  flow_id;
        logic [15:0] payload_length;
    } t_result;

endpackage

/* hdl/gtpu_header_parser_core.sv */
// top level of the gtp-u v1 header parser
//
//  channel   dir  handshake               contents
//  s side    in   i_s_tvalid/o_s_tready   one packet byte, tlast on the final byte
//  m side    out  o_m_tvalid/i_m_tready   payload byte or final status beat
//
// one byte is taken every cycle while o_s_tready is high; the parse state is a
// single register set updated by each accepted beat; results are registered.
// header bytes before the final one give no output beat.
// o_s_tready drops only when the result register and the skid slot are both full.
// reset (synchronous, active low) returns the parser to the start of a packet
// and empties both output slots.
module gtpu_header_parser_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // [7:0] payload_byte, [10:8] error_code,
                                     // [42:11] tunnel_id, [48:43] flow_id,
                                     // [64:49] payload_length, [71:65] zero
    output logic        o_m_tlast,   // done_res
    output logic        o_m_tuser    // payload_valid
);

    logic              accept;
    logic              res_valid;
    gtpu_pkg::t_result res;
    gtpu_pkg::t_result out_res;

    assign accept = i_s_tvalid && o_s_tready;

    gtpu_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_s_tdata),
        .i_last_byte (i_s_tlast),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    gtpu_out_skid u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .o_data      (out_res),
        .i_pop_ready (i_m_tready)
    );

    // pack the output beat
    assign o_m_tdata = {7'b0000000,
                        out_res.payload_length,
                        out_res.flow_id,
                        out_res.tunnel_id,
                        out_res.error_code,
                        out_res.payload_byte};
    assign o_m_tlast = out_res.done_res;
    assign o_m_tuser = out_res.payload_valid;

endmodule

/* hdl/gtpu_parse.sv */
// parse state registers and the per-beat header decode
module gtpu_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [7:0]         i_data_byte,
    input  logic               i_last_byte,
    output logic               o_res_valid,
    output gtpu_pkg::t_result  o_res
);

    gtpu_pkg::t_count r_count, n_count;
    gtpu_pkg::t_phase r_phase, n_phase;
    gtpu_pkg::t_hdr   r_hdr_end, n_hdr_end;
    gtpu_pkg::t_hdr   r_ext_start, n_ext_start;
    logic [7:0]       r_next_ext, n_next_ext;
    logic [7:0]       r_flags, n_flags;
    logic [31:0]      r_teid, n_teid;
    logic [5:0]       r_qfi, n_qfi;
    gtpu_pkg::t_err   r_err, n_err;

    gtpu_pkg::t_phase phase_now;
    gtpu_pkg::t_err   code;
    gtpu_pkg::t_hdr   pos_ext;
    gtpu_pkg::t_plen  plen;
    logic             pay;

    assign pos_ext = gtpu_pkg::t_hdr'(r_count);

    // next parse state for the current beat
    always_comb begin
        n_count     = r_count;
        n_phase     = r_phase;
        n_hdr_end   = r_hdr_end;
        n_ext_start = r_ext_start;
        n_next_ext  = r_next_ext;
        n_flags     = r_flags;
        n_teid      = r_teid;
        n_qfi       = r_qfi;
        n_err       = r_err;
        pay         = 1'b0;
        phase_now   = r_phase;

        // counter saturates, a beat at the maximum is an overflow
        if (r_count == '1) begin
            if (r_err == gtpu_pkg::ERR_OK) begin
                n_err = gtpu_pkg::ERR_OVERFLOW;
            end
            n_phase   = gtpu_pkg::PH_DROP;
            phase_now = gtpu_pkg::PH_DROP;
        end else begin
            n_count = r_count + gtpu_pkg::t_count'(1);
        end

        case (phase_now)
            gtpu_pkg::PH_FIXED: begin
                if (r_count == gtpu_pkg::t_count'(0)) begin
                    n_flags = i_data_byte;
                    if ((i_data_byte & gtpu_pkg::VER_MASK) != gtpu_pkg::VER_ONE ||
                        !i_data_byte[4]) begin
                        n_err   = gtpu_pkg::ERR_VERSION;
                        n_phase = gtpu_pkg::PH_DROP;
                    end
                end else if (r_count == gtpu_pkg::t_count'(1)) begin
                    if (i_data_byte != gtpu_pkg::MSG_GPDU) begin
                        n_err   = gtpu_pkg::ERR_NOT_GPDU;
                        n_phase = gtpu_pkg::PH_DROP;
                    end
                end else if (r_count >= gtpu_pkg::t_count'(4)) begin
                    n_teid = {r_teid[23:0], i_data_byte};
                    if (r_count == gtpu_pkg::t_count'(gtpu_pkg::FIXED_LEN - 1)) begin
                        // any of e, s or pn brings the optional word
                        if (r_flags[2:0] != 3'b000) begin
                            n_hdr_end = gtpu_pkg::t_hdr'(gtpu_pkg::OPT_END);
                            n_phase   = gtpu_pkg::PH_OPT;
                        end else begin
                            n_hdr_end = gtpu_pkg::t_hdr'(gtpu_pkg::FIXED_LEN);
                            n_phase   = gtpu_pkg::PH_PAYLOAD;
                        end
                    end
                end
            end
            gtpu_pkg::PH_OPT: begin
                if (r_count == gtpu_pkg::t_count'(gtpu_pkg::OPT_END - 1)) begin
                    n_next_ext = i_data_byte;
                    if (r_flags[2] && i_data_byte != gtpu_pkg::EXT_NONE) begin
                        n_ext_start = gtpu_pkg::t_hdr'(gtpu_pkg::OPT_END);
                        n_phase     = gtpu_pkg::PH_EXT_LEN;
                    end else begin
                        n_phase = gtpu_pkg::PH_PAYLOAD;
                    end
                end
            end
            gtpu_pkg::PH_EXT_LEN: begin
                if (i_data_byte == 8'h00) begin
                    if (r_err == gtpu_pkg::ERR_OK) begin
                        n_err = gtpu_pkg::ERR_EXT_ZERO;
                    end
                    n_phase = gtpu_pkg::PH_DROP;
                end else begin
                    // length counts 4-byte units
                    n_hdr_end = r_ext_start + gtpu_pkg::t_hdr'({i_data_byte, 2'b00});
                    n_phase   = gtpu_pkg::PH_EXT_BODY;
                end
            end
            gtpu_pkg::PH_EXT_BODY: begin
                // qfi sits in the third byte of a pdu session container
                if (pos_ext == r_ext_start + gtpu_pkg::t_hdr'(2) &&
                    r_next_ext == gtpu_pkg::EXT_PDU_SESS) begin
                    n_qfi = i_data_byte[5:0] & gtpu_pkg::QFI_MASK;
                end
                // last byte of an extension names the next one
                if (pos_ext == r_hdr_end - gtpu_pkg::t_hdr'(1)) begin
                    n_next_ext = i_data_byte;
                    if (i_data_byte == gtpu_pkg::EXT_NONE) begin
                        n_phase = gtpu_pkg::PH_PAYLOAD;
                    end else begin
                        n_ext_start = r_hdr_end;
                        n_phase     = gtpu_pkg::PH_EXT_LEN;
                    end
                end
            end
            gtpu_pkg::PH_PAYLOAD: begin
                pay = 1'b1;
            end
            default: begin
                pay = 1'b0;
            end
        endcase
    end

    // final status and payload length
    always_comb begin
        code = n_err;
        if (n_count < gtpu_pkg::t_count'(gtpu_pkg::FIXED_LEN)) begin
            code = gtpu_pkg::ERR_SHORT;
        end else if (code == gtpu_pkg::ERR_OK) begin
            if (n_phase == gtpu_pkg::PH_OPT) begin
                code = gtpu_pkg::ERR_SHORT_OPT;
            end else if (n_phase == gtpu_pkg::PH_EXT_BODY) begin
                code = gtpu_pkg::ERR_EXT_TRUNC;
            end
        end

        plen = '0;
        if (n_phase == gtpu_pkg::PH_PAYLOAD &&
            gtpu_pkg::t_hdr'(n_count) > n_hdr_end) begin
            plen = gtpu_pkg::t_plen'(n_count) - gtpu_pkg::t_plen'(n_hdr_end);
        end
        if (plen > gtpu_pkg::t_plen'(16'hFFFF)) begin
            plen = gtpu_pkg::t_plen'(16'hFFFF);
        end
    end

    // result item for this beat
    always_comb begin
        o_res                = '0;
        o_res.payload_valid  = pay && (n_err == gtpu_pkg::ERR_OK);
        o_res.payload_byte   = o_res.payload_valid ? i_data_byte : 8'h00;
        o_res.done_res       = i_last_byte;
        o_res.error_code     = gtpu_pkg::ERR_OK;
        if (i_last_byte) begin
            o_res.error_code = code;
            if (code == gtpu_pkg::ERR_OK) begin
                o_res.tunnel_id      = n_teid;
                o_res.flow_id        = n_qfi;
                o_res.payload_length = plen[15:0];
            end
        end
        o_res_valid = i_accept && (o_res.payload_valid || i_last_byte);
    end

    // state update, back to the start after each final beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last_byte)) begin
            r_count     <= '0;
            r_phase     <= gtpu_pkg::PH_FIXED;
            r_hdr_end   <= gtpu_pkg::t_hdr'(gtpu_pkg::FIXED_LEN);
            r_ext_start <= '0;
            r_next_ext  <= '0;
            r_flags     <= '0;
            r_teid      <= '0;
            r_qfi       <= '0;
            r_err       <= gtpu_pkg::ERR_OK;
        end else if (i_accept) begin
            r_count     <= n_count;
            r_phase     <= n_phase;
            r_hdr_end   <= n_hdr_end;
            r_ext_start <= n_ext_start;
            r_next_ext  <= n_next_ext;
            r_flags     <= n_flags;
            r_teid      <= n_teid;
            r_qfi       <= n_qfi;
            r_err       <= n_err;
        end
    end

endmodule

/* hdl/gtpu_out_skid.sv */
// result register with a skid slot for the output stream
module gtpu_out_skid (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  gtpu_pkg::t_result  i_data,
    output logic               o_ready,
    output logic               o_valid,
    output gtpu_pkg::t_result  o_data,
    input  logic               i_pop_ready
);

    logic              r_main_v;
    logic              r_skid_v;
    gtpu_pkg::t_result r_main;
    gtpu_pkg::t_result r_skid;
    logic              pop;

    assign pop     = r_main_v && i_pop_ready;
    assign o_ready = !r_skid_v;
    assign o_valid = r_main_v;
    assign o_data  = r_main;

    // valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (pop) begin
                r_skid_v <= 1'b0;
            end
        end else if (pop || !r_main_v) begin
            r_main_v <= i_push;
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // data slots
    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (pop) begin
                r_main <= r_skid;
            end
        end else if (pop || !r_main_v) begin
            r_main <= i_data;
        end else if (i_push) begin
            r_skid <= i_data;
        end
    end

endmodule

/* hdl/gtpu_checker.sv */
// port checks for the gtp-u header parser, bound to the top level
module gtpu_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    // stalled output beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("output beat changed while stalled");

    // a beat that is not final always carries payload and no status
    a_mid_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser && (o_m_tdata[71:8] == '0))
        else $error("non-final beat without payload or with status");

    // an error hides tunnel, flow and length
    a_err_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[10:8] != 3'd0) |-> (o_m_tdata[71:11] == '0))
        else $error("status fields set on an error beat");

    // no payload flag means no payload byte
    a_byte_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> (o_m_tdata[7:0] == 8'h00))
        else $error("payload byte set without payload flag");

    // output slots are empty right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_tready && !o_m_tvalid)
        else $error("output not empty after reset");

endmodule

bind gtpu_header_parser_core gtpu_checker u_gtpu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);

/* tb/sv/tb_gtpu_header_parser_core.sv */
// testbench of the gtp-u v1 header parser: byte stream in, payload and status beats checked
module tb_gtpu_header_parser_core;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_BYTES = 640;
    localparam gtpu_pkg::t_count MAX_COUNT = '1;

    // tracks one packet parse and holds the beats the parser owes us
    class gtpu_parse_tracker;
        gtpu_pkg::t_count  count;
        gtpu_pkg::t_phase  phase;
        gtpu_pkg::t_hdr    header_end;
        gtpu_pkg::t_hdr    ext_start;
        logic [7:0]        next_type;
        logic [7:0]        flags;
        logic [31:0]       teid;
        logic [5:0]        qfi;
        gtpu_pkg::t_err    err;
        gtpu_pkg::t_result expected_beats[$];
        int                fails;

        function new();
            fails = 0;
            restart();
        endfunction

        function void restart();
            count      = '0;
            phase      = gtpu_pkg::PH_FIXED;
            header_end = gtpu_pkg::t_hdr'(gtpu_pkg::FIXED_LEN);
            ext_start  = '0;
            next_type  = gtpu_pkg::EXT_NONE;
            flags      = 8'h00;
            teid       = '0;
            qfi        = '0;
            err        = gtpu_pkg::ERR_OK;
        endfunction

        function void latch(gtpu_pkg::t_err code);
            if (err == gtpu_pkg::ERR_OK)
                err = code;
            phase = gtpu_pkg::PH_DROP;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // advance the parse by one accepted byte
        function void take_byte(logic [7:0] b, logic last);
            gtpu_pkg::t_count  pos;
            gtpu_pkg::t_count  len;
            gtpu_pkg::t_err    code;
            gtpu_pkg::t_result r;
            logic              pay;
            int                plen;
            pos = count;
            pay = 1'b0;
            r   = '0;

            // saturating byte counter
            if (pos >= MAX_COUNT)
                latch(gtpu_pkg::ERR_OVERFLOW);
            else
                count = pos + 1'b1;

            case (phase)
                gtpu_pkg::PH_FIXED: begin
                    if (pos == 0) begin
                        flags = b;
                        if ((b & gtpu_pkg::VER_MASK) != gtpu_pkg::VER_ONE || b[4] == 1'b0)
                            latch(gtpu_pkg::ERR_VERSION);
                    end else if (pos == 1) begin
                        if (b != gtpu_pkg::MSG_GPDU)
                            latch(gtpu_pkg::ERR_NOT_GPDU);
                    end else if (pos >= 4) begin
                        teid = {teid[23:0], b};
                        if (pos == 7) begin
                            if (flags[2:0] != 3'b000) begin
                                header_end = gtpu_pkg::t_hdr'(gtpu_pkg::OPT_END);
                                phase = gtpu_pkg::PH_OPT;
                            end else begin
                                header_end = gtpu_pkg::t_hdr'(gtpu_pkg::FIXED_LEN);
                                phase = gtpu_pkg::PH_PAYLOAD;
                            end
                        end
                    end
                end
                gtpu_pkg::PH_OPT: begin
                    if (pos == gtpu_pkg::OPT_END - 1) begin
                        next_type = b;
                        if (flags[2] && b != gtpu_pkg::EXT_NONE) begin
                            ext_start = gtpu_pkg::t_hdr'(gtpu_pkg::OPT_END);
                            phase = gtpu_pkg::PH_EXT_LEN;
                        end else begin
                            phase = gtpu_pkg::PH_PAYLOAD;
                        end
                    end
                end
                gtpu_pkg::PH_EXT_LEN: begin
                    if (b == 8'h00) begin
                        latch(gtpu_pkg::ERR_EXT_ZERO);
                    end else begin
                        header_end = ext_start + gtpu_pkg::t_hdr'(gtpu_pkg::EXT_UNIT * b);
                        phase = gtpu_pkg::PH_EXT_BODY;
                    end
                end
                gtpu_pkg::PH_EXT_BODY: begin
                    if (pos == ext_start + 2 && next_type == gtpu_pkg::EXT_PDU_SESS)
                        qfi = b[5:0] & gtpu_pkg::QFI_MASK;
                    if (pos == header_end - 1) begin
                        next_type = b;
                        if (b == gtpu_pkg::EXT_NONE) begin
                            phase = gtpu_pkg::PH_PAYLOAD;
                        end else begin
                            ext_start = header_end;
                            phase = gtpu_pkg::PH_EXT_LEN;
                        end
                    end
                end
                gtpu_pkg::PH_PAYLOAD: begin
                    pay = 1'b1;
                end
                default: begin
                end
            endcase

            if (pay && err == gtpu_pkg::ERR_OK) begin
                r.payload_valid = 1'b1;
                r.payload_byte  = b;
            end

            // status on the final byte
            if (last) begin
                len  = count;
                code = err;
                if (len < gtpu_pkg::FIXED_LEN)
                    code = gtpu_pkg::ERR_SHORT;
                else if (code == gtpu_pkg::ERR_OK && phase == gtpu_pkg::PH_OPT)
                    code = gtpu_pkg::ERR_SHORT_OPT;
                else if (code == gtpu_pkg::ERR_OK && phase == gtpu_pkg::PH_EXT_BODY)
                    code = gtpu_pkg::ERR_EXT_TRUNC;
                r.done_res   = 1'b1;
                r.error_code = code;
                if (code == gtpu_pkg::ERR_OK) begin
                    plen = 0;
                    if (phase == gtpu_pkg::PH_PAYLOAD && len > header_end)
                        plen = int'(len) - int'(header_end);
                    if (plen > 65535)
                        plen = 65535;
                    r.tunnel_id      = teid;
                    r.flow_id        = qfi;
                    r.payload_length = 16'(plen);
                end
                restart();
            end

            if (r.payload_valid || r.done_res)
                expected_beats.push_back(r);
        endfunction

        function void compare(string field, longint unsigned want, longint unsigned got);
            if (want != got) begin
                $display("%0t: %s expected %0h got %0h", $time, field, want, got);
                fails++;
            end
        endfunction

        // check one output beat against the oldest expectation
        function void match_beat(logic [71:0] data, logic last, logic user);
            gtpu_pkg::t_result want;
            if (expected_beats.size() == 0) begin
                $display("%0t: unexpected beat expected none got data %0h last %b user %b",
                         $time, data, last, user);
                fails++;
                return;
            end
            want = expected_beats.pop_front();
            compare("payload_valid", want.payload_valid, user);
            compare("payload_byte", want.payload_byte, data[7:0]);
            compare("done_res", want.done_res, last);
            compare("error_code", want.error_code, data[10:8]);
            compare("tunnel_id", want.tunnel_id, data[42:11]);
            compare("flow_id", want.flow_id, data[48:43]);
            compare("payload_length", want.payload_length, data[64:49]);
            compare("tdata pad", 0, data[71:65]);
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    gtpu_parse_tracker tracker = new();
    logic [7:0] pkt[$];
    logic       calm = 1'b0;
    int         beats_seen = 0;
    int         cycles = 0;

    gtpu_header_parser_core uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tlast  (s_tlast),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    // clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // run guard
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            tracker.match_beat(m_tdata, m_tlast, m_tuser);
            beats_seen++;
        end
    end

    // receiver stalls, drawn once per beat
    always @(negedge i_clk) begin
        int beats_handled;
        int unsigned hold;
        if (beats_seen != beats_handled) begin
            beats_handled = beats_seen;
            hold = calm ? 0 : $urandom_range(0, 17);
        end
        if (hold != 0) begin
            hold--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // one input beat after a random gap
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = calm ? 0 : $urandom_range(0, 17);
        repeat (gap) begin
            @(negedge i_clk);
            s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge i_clk);
        while (!s_tready)
            @(posedge i_clk);
        tracker.take_byte(b, last);
    endtask

    task automatic send_packet();
        int k;
        for (k = 0; k < pkt.size(); k++)
            send_byte(pkt[k], k == pkt.size() - 1);
    endtask

    // hold the sender until the parser has delivered everything
    task automatic drain();
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_ext_type();
        return ($urandom_range(0, 1) != 0) ? gtpu_pkg::EXT_PDU_SESS : 8'($urandom);
    endfunction

    // mostly well-formed packets with random content, some broken or pure noise
    task automatic build_packet();
        int unsigned style;
        int unsigned nexts;
        int unsigned ulen;
        int unsigned cut;
        int unsigned k;
        logic [7:0]  flg;
        logic [7:0]  nxt;
        pkt.delete();
        style = $urandom_range(0, 19);
        if (style < 2) begin
            repeat ($urandom_range(1, 24)) pkt.push_back(8'($urandom));
            return;
        end
        flg = 8'h30 | 8'($urandom_range(0, 15));
        pkt.push_back(flg);
        pkt.push_back(gtpu_pkg::MSG_GPDU);
        repeat (6) pkt.push_back(8'($urandom));
        if (flg[2:0] != 3'b000) begin
            repeat (3) pkt.push_back(8'($urandom));
            nxt = flg[2] ? pick_ext_type() : 8'($urandom);
            pkt.push_back(nxt);
            nexts = $urandom_range(1, 3);
            // extension walk, length byte then the rest of the 4-byte units
            while (flg[2] && nxt != gtpu_pkg::EXT_NONE) begin
                if ($urandom_range(0, 19) == 0) begin
                    pkt.push_back(8'h00);
                    break;
                end
                ulen = ($urandom_range(0, 39) == 0) ? $urandom_range(4, 255)
                                                    : $urandom_range(1, 3);
                nexts--;
                nxt = (nexts == 0) ? gtpu_pkg::EXT_NONE : pick_ext_type();
                pkt.push_back(8'(ulen));
                for (k = 0; k < 4 * ulen - 1; k++)
                    pkt.push_back((k == 4 * ulen - 2) ? nxt : 8'($urandom));
            end
        end
        repeat ($urandom_range(0, 24)) pkt.push_back(8'($urandom));
        // damage
        if (style < 4) begin
            cut = $urandom_range(1, pkt.size());
            while (pkt.size() > cut)
                pkt.pop_back();
        end else if (style == 4) begin
            pkt[0] = 8'($urandom);
        end else if (style == 5) begin
            pkt[1] = 8'($urandom);
        end else if (style == 6) begin
            pkt[$urandom_range(0, pkt.size() - 1)] = 8'($urandom);
        end
    endtask

    // stimulus
    initial begin
        int random_bytes;
        random_bytes = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // single byte, short wins over a bad flags byte
        pkt = {8'h00};
        send_packet();
        // minimal valid header, no payload
        pkt = {8'h30, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();
        // all-ones teid with two payload bytes
        pkt = {8'h30, 8'hFF, 8'h12, 8'h34, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF};
        send_packet();
        drain();
        // bad version, then protocol type clear
        pkt = {8'h50, 8'hFF, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44};
        send_packet();
        pkt = {8'h20, 8'hFF, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44};
        send_packet();
        // not a g-pdu, and the first error winning over it
        pkt = {8'h30, 8'hFE, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44};
        send_packet();
        pkt = {8'h20, 8'hFE, 8'h00, 8'h00, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55};
        send_packet();
        // optional part cut short
        pkt = {8'h32, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h00, 8'h01};
        send_packet();
        // zero extension length
        pkt = {8'h34, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
               8'h00, 8'h00, 8'h00, 8'h85, 8'h00, 8'h9A};
        send_packet();
        // extension truncated
        pkt = {8'h34, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
               8'h00, 8'h00, 8'h00, 8'h85, 8'h01, 8'h00};
        send_packet();
        // two session containers, the second qfi wins
        pkt = {8'h34, 8'hFF, 8'h00, 8'h08, 8'hA1, 8'hB2, 8'hC3, 8'hD4,
               8'h00, 8'h00, 8'h00, 8'h85, 8'h01, 8'h00, 8'hFF, 8'h85,
               8'h01, 8'h00, 8'hC5, 8'h00, 8'hAB, 8'hCD};
        send_packet();
        // packet ends where the next extension would start
        pkt = {8'h34, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
               8'h00, 8'h00, 8'h00, 8'h85, 8'h01, 8'h00, 8'h07, 8'h85};
        send_packet();
        // sequence flag only, next type ignored
        pkt = {8'h32, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
               8'h00, 8'h00, 8'h00, 8'h85, 8'hDE, 8'hAD};
        send_packet();
        // other extension type, two units long
        pkt = {8'h34, 8'hFF, 8'h00, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04,
               8'h00, 8'h00, 8'h00, 8'hC0, 8'h02, 8'h11, 8'h22, 8'h33,
               8'h44, 8'h55, 8'h66, 8'h00, 8'h77};
        send_packet();
        drain();

        // random packets
        while (random_bytes < RANDOM_BYTES) begin
            calm = ($urandom_range(0, 3) == 0);
            build_packet();
            random_bytes += pkt.size();
            send_packet();
            if ($urandom_range(0, 7) == 0)
                drain();
        end

        // wind down
        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (tracker.fails == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
